FILE: design/rmq_pkg.sv
package rmq_pkg;

  // fixed field widths of the channels
  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned PosFieldWidth = 7;
  localparam int unsigned RangeWidth    = 8;
  localparam int unsigned CountWidth    = 8;

  // default tree size (number of leaves)
  localparam int unsigned SizeDefault = 128;

  // element count after reset
  localparam logic [CountWidth-1:0] CountReset = CountWidth'(128);

  // flipping the sign bit makes unsigned order equal signed order
  localparam logic [ValueWidth-1:0] SignFlip = {1'b1, {(ValueWidth-1){1'b0}}};

  // action codes
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LLEAF,
    S_LUP,
    S_QWALK,
    S_QDONE
  } state_e;

endpackage

FILE: design/rmq_if.sv
interface rmq_in_if;
  import rmq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [PosFieldWidth-1:0] position;
  logic signed [ValueWidth-1:0] value;
  logic [RangeWidth-1:0]    range_low;
  logic [RangeWidth-1:0]    range_high;

  modport source (output valid, action, position, value, range_low, range_high,
                  input ready);
  modport sink   (input valid, action, position, value, range_low, range_high,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueWidth-1:0] max_value;
  logic [PosFieldWidth-1:0] max_index;
  logic                     found;

  modport source (output valid, max_value, max_index, found, input ready);
  modport sink   (input valid, max_value, max_index, found, output ready);
endinterface

interface rmq_cfg_if;
  import rmq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/range_max_query_tree.sv
// channel  | dir | port  | beat contents
// ---------+-----+-------+-------------------------------------------------
// input    | in  | in_i  | action, position, value, range_low, range_high
// result   | out | out_o | max_value, max_index, found (queries only)
// config   | in  | cfg_i | element_count, always ready
//
// a load writes the leaf, then climbs one level at a time, merging the sibling pair into each parent
// a query reads the left edge and the right edge where needed and climbs at each level, as the node
// memory has one read port; an empty range goes straight to the result
// input is taken only while idle; a finished result waits in the output register and the
// sequencer holds in its final state while that register is full
// reset clears control state and sets element_count to 128; the node memory is not cleared
module range_max_query_tree #(
  parameter int unsigned SIZE = rmq_pkg::SizeDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o,
  rmq_cfg_if.sink   cfg_i
);
  import rmq_pkg::*;

  // widths derived from the tree size
  localparam int unsigned PosW  = $clog2(SIZE);
  localparam int unsigned Depth = 2 * SIZE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned NodeW = ValueWidth + PosW;
  // walk indices reach 2*SIZE and must hold the 8-bit range fields
  localparam int unsigned LW    = (AddrW + 1 > 9) ? AddrW + 1 : 9;

  state_e state_q, state_d;

  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [LW-1:0]         l_q, l_d;         // left edge, or current node on load
  logic [LW-1:0]         r_q, r_d;         // right edge (exclusive)
  logic [ValueWidth-1:0] node_key_q, node_key_d;   // running best / current node
  logic [PosW-1:0]       node_pos_q, node_pos_d;
  logic                  any_q, any_d;     // best holds a real node
  logic                  pend_q, pend_d;   // read data due this cycle

  logic                     out_valid_q, out_valid_d;
  logic [ValueWidth-1:0]    out_value_q, out_value_d;
  logic [PosFieldWidth-1:0] out_index_q, out_index_d;
  logic                     out_found_q, out_found_d;

  // memory port
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [NodeW-1:0] mem_wdata, mem_rdata;
  logic [ValueWidth-1:0] rd_key;
  logic [PosW-1:0]       rd_pos;

  // shared compare unit
  logic [ValueWidth-1:0] win_key;
  logic [PosW-1:0]       win_pos;

  // query clipping
  logic [LW-1:0] size_l, cnt_l, eff_cnt, lo_c, hi_c, raw_lo, raw_hi, parent;
  logic          in_fire;

  assign rd_key = mem_rdata[NodeW-1:PosW];
  assign rd_pos = mem_rdata[PosW-1:0];

  // the user must load every position below the count before a query reads its nodes; the block does not enforce it
  rmq_ram #(
    .WIDTH (NodeW),
    .DEPTH (Depth)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rmq_pick #(
    .KEY_W (ValueWidth),
    .POS_W (PosW)
  ) u_pick (
    .a_key_i (node_key_q),
    .a_pos_i (node_pos_q),
    .b_key_i (rd_key),
    .b_pos_i (rd_pos),
    .key_o   (win_key),
    .pos_o   (win_pos)
  );

  // handshake
  assign in_i.ready     = (state_q == S_IDLE);
  assign in_fire        = in_i.valid && in_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.max_value = out_value_q;
  assign out_o.max_index = out_index_q;
  assign out_o.found     = out_found_q;

  // clip the range to min(count, SIZE)
  assign size_l  = LW'(SIZE);
  assign cnt_l   = LW'(cnt_q);
  assign eff_cnt = (cnt_l < size_l) ? cnt_l : size_l;
  assign raw_lo  = LW'(in_i.range_low);
  assign raw_hi  = LW'(in_i.range_high);
  assign lo_c    = (raw_lo > eff_cnt) ? eff_cnt : raw_lo;
  assign hi_c    = (raw_hi > eff_cnt) ? eff_cnt : raw_hi;
  assign parent  = l_q >> 1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    l_d         = l_q;
    r_d         = r_q;
    node_key_d  = node_key_q;
    node_pos_d  = node_pos_q;
    any_d       = any_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_index_d = out_index_q;
    out_found_d = out_found_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = l_q[AddrW-1:0];
    mem_raddr   = l_q[AddrW-1:0];
    mem_wdata   = {node_key_q, node_pos_q};

    if (cfg_i.valid) begin
      cnt_d = cfg_i.data;
    end

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.action == ActLoad) begin
            // positions outside the tree are dropped
            if (LW'(in_i.position) < size_l) begin
              l_d        = size_l + LW'(in_i.position);
              node_key_d = in_i.value ^ SignFlip;
              node_pos_d = PosW'(in_i.position);
              state_d    = S_LLEAF;
            end
          end else begin
            any_d  = 1'b0;
            pend_d = 1'b0;
            l_d    = lo_c + size_l;
            r_d    = hi_c + size_l;
            // empty range goes straight to the result
            state_d = (lo_c >= hi_c) ? S_QDONE : S_QWALK;
          end
        end
      end

      S_LLEAF: begin
        // write the leaf, fetch its sibling
        mem_we    = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = l_q[AddrW-1:0] ^ AddrW'(1);
        state_d   = S_LUP;
      end

      S_LUP: begin
        // merge with sibling into the parent, fetch the parent's sibling unless the parent is the root
        mem_we     = 1'b1;
        mem_waddr  = parent[AddrW-1:0];
        mem_wdata  = {win_key, win_pos};
        node_key_d = win_key;
        node_pos_d = win_pos;
        l_d        = parent;
        if (parent == LW'(1)) begin
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent[AddrW-1:0] ^ AddrW'(1);
        end
      end

      S_QWALK: begin
        // fold the node read last cycle
        if (pend_q) begin
          node_key_d = any_q ? win_key : rd_key;
          node_pos_d = any_q ? win_pos : rd_pos;
          any_d      = 1'b1;
        end
        if (l_q < r_q) begin
          if (l_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = l_q[AddrW-1:0];
            l_d       = l_q + LW'(1);
            pend_d    = 1'b1;
          end else if (r_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = AddrW'(r_q - LW'(1));
            r_d       = r_q - LW'(1);
            pend_d    = 1'b1;
          end else begin
            l_d    = l_q >> 1;
            r_d    = r_q >> 1;
            pend_d = 1'b0;
          end
        end else begin
          pend_d  = 1'b0;
          state_d = S_QDONE;
        end
      end

      S_QDONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = any_q;
          out_value_d = any_q ? (node_key_q ^ SignFlip) : '0;
          out_index_d = any_q ? PosFieldWidth'(node_pos_q) : '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CountReset;
      any_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      any_q       <= any_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    l_q         <= l_d;
    r_q         <= r_d;
    node_key_q  <= node_key_d;
    node_pos_q  <= node_pos_d;
    out_value_q <= out_value_d;
    out_index_q <= out_index_d;
    out_found_q <= out_found_d;
  end

`ifndef NO_ASSERTIONS
  // a new result only comes out of the final query state
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_QDONE)
    else $error("result raised outside query completion");

  // an empty result carries zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_value_q == '0 && out_index_q == '0))
    else $error("empty result with nonzero payload");

  // the climb never runs past the root
  a_climb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LUP) |-> (l_q > LW'(1)))
    else $error("load walk above root");

  // a node is never read at the address written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same node");
`endif

endmodule

FILE: design/rmq_ram.sv
module rmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rmq_pick.sv
module rmq_pick #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned POS_W = 7
) (
  input  logic [KEY_W-1:0] a_key_i,
  input  logic [POS_W-1:0] a_pos_i,
  input  logic [KEY_W-1:0] b_key_i,
  input  logic [POS_W-1:0] b_pos_i,
  output logic [KEY_W-1:0] key_o,
  output logic [POS_W-1:0] pos_o
);

  logic a_wins;

  // larger key wins, equal keys go to the larger position
  assign a_wins = (a_key_i > b_key_i) || ((a_key_i == b_key_i) && (a_pos_i > b_pos_i));
  assign key_o  = a_wins ? a_key_i : b_key_i;
  assign pos_o  = a_wins ? a_pos_i : b_pos_i;

endmodule

FILE: tb/tb_range_max_query_tree.sv
`timescale 1ns / 1ps

module tb_range_max_query_tree;
  import rmq_pkg::*;

  // one beat on the input channel and one on the result channel
  typedef struct packed {
    logic                         action;
    logic [PosFieldWidth-1:0]     position;
    logic signed [ValueWidth-1:0] value;
    logic [RangeWidth-1:0]        range_low;
    logic [RangeWidth-1:0]        range_high;
  } rmq_req_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] max_value;
    logic [PosFieldWidth-1:0]     max_index;
    logic                         found;
  } rmq_res_t;

  // mirror of the element array and the count register, plus the queue of
  // maxima that the block still owes us
  class range_max_tracker;
    logic signed [ValueWidth-1:0] elements [SizeDefault];
    int unsigned count_cfg;
    rmq_res_t    pending_maxima [$];
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_loads;
    int unsigned n_queries;
    int unsigned n_empty;

    function new();
      count_cfg  = CountReset;
      mismatches = 0;
      n_checked  = 0;
      n_loads    = 0;
      n_queries  = 0;
      n_empty    = 0;
      foreach (elements[i]) elements[i] = '0;
    endfunction

    function void set_count(int unsigned c);
      count_cfg = c;
    endfunction

    // rightmost maximum over the clipped half-open range
    function rmq_res_t range_max(int unsigned lo, int unsigned hi);
      rmq_res_t                     r;
      int unsigned                  cnt;
      logic signed [ValueWidth-1:0] best_v;
      int unsigned                  best_i;
      r   = '0;
      cnt = (count_cfg < SizeDefault) ? count_cfg : SizeDefault;
      if (lo > cnt) lo = cnt;
      if (hi > cnt) hi = cnt;
      if (lo >= hi) return r;
      best_v = elements[lo];
      best_i = lo;
      for (int unsigned i = lo + 1; i < hi; i++) begin
        if (elements[i] >= best_v) begin
          best_v = elements[i];
          best_i = i;
        end
      end
      r.found     = 1'b1;
      r.max_value = best_v;
      r.max_index = PosFieldWidth'(best_i);
      return r;
    endfunction

    function void note_beat(rmq_req_t b);
      rmq_res_t r;
      if (b.action == ActLoad) begin
        elements[b.position] = b.value;
        n_loads++;
      end else begin
        r = range_max(b.range_low, b.range_high);
        if (!r.found) n_empty++;
        n_queries++;
        pending_maxima.push_back(r);
      end
    endfunction

    function void check_result(rmq_res_t got);
      rmq_res_t want;
      if (pending_maxima.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with no query waiting: found=%0b value=%0d index=%0d",
                   $realtime, got.found, got.max_value, got.max_index);
        mismatches++;
        return;
      end
      want = pending_maxima.pop_front();
      n_checked++;
      if (got.found !== want.found || got.max_value !== want.max_value ||
          got.max_index !== want.max_index) begin
        if (mismatches < 10)
          $display("%0t: result %0d: expected found=%0b value=%0d index=%0d, got found=%0b value=%0d index=%0d",
                   $realtime, n_checked, want.found, want.max_value, want.max_index,
                   got.found, got.max_value, got.max_index);
        mismatches++;
      end
    endfunction
  endclass

  // a load walks 7 levels and a query makes up to 2 reads and a climb per level, so this
  // covers a trailing load or a result parked in the output register
  localparam int unsigned DrainCycles = 64;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rmq_in_if  in_if ();
  rmq_out_if out_if ();
  rmq_cfg_if cfg_if ();

  range_max_tracker tracker = new();

  // sender pacing state
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;
  int unsigned n_cfg      = 0;

  range_max_query_tree u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", tracker.pending_maxima.size());
    $display("** range_max_query_tree: FAILED **");
    $finish;
  end

  // value mix: extremes, a narrow band around zero to force ties, and noise
  function automatic logic signed [ValueWidth-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed(ValueWidth'($urandom_range(0, 4))) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic rmq_req_t load_beat(int unsigned p, logic signed [ValueWidth-1:0] v);
    rmq_req_t b;
    b.action     = ActLoad;
    b.position   = PosFieldWidth'(p);
    b.value      = v;
    // range fields are don't-care on a load, toggle them anyway
    b.range_low  = RangeWidth'($urandom_range(0, SizeDefault));
    b.range_high = RangeWidth'($urandom_range(0, SizeDefault));
    return b;
  endfunction

  function automatic rmq_req_t query_beat(int unsigned lo, int unsigned hi);
    rmq_req_t b;
    b.action     = ActQuery;
    b.position   = PosFieldWidth'($urandom_range(0, SizeDefault - 1));
    b.value      = $urandom;
    b.range_low  = RangeWidth'(lo);
    b.range_high = RangeWidth'(hi);
    return b;
  endfunction

  // random beat shaped around the current element count
  function automatic rmq_req_t rand_item(int unsigned cnt);
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(0, 99) < 45)
      return load_beat($urandom_range(0, SizeDefault - 1), rand_value());
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // well-formed range inside the count
        lo = $urandom_range(0, cnt);
        hi = $urandom_range(lo, cnt);
      end
      5: begin
        // range that runs past the count and gets clipped
        lo = (cnt > 3) ? cnt - $urandom_range(1, 3) : 0;
        hi = $urandom_range(cnt, SizeDefault);
      end
      6: begin
        // anything the fields allow, reversed ranges included
        lo = $urandom_range(0, SizeDefault);
        hi = $urandom_range(0, SizeDefault);
      end
      7: begin
        lo = $urandom_range(0, cnt - 1);
        hi = lo + 1;
      end
      8: begin
        lo = $urandom_range(0, SizeDefault);
        hi = lo;
      end
      default: begin
        lo = 0;
        hi = SizeDefault;
      end
    endcase
    return query_beat(lo, hi);
  endfunction

  // drive one beat at the falling edge, hold it until accepted, then return
  // at the next falling edge with valid still high; bursts of random length
  // are broken by random gaps unless the phase runs gap-free
  task automatic send(rmq_req_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = no_gaps ? 1000 : $urandom_range(1, 16);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= b.action;
    in_if.position   <= b.position;
    in_if.value      <= b.value;
    in_if.range_low  <= b.range_low;
    in_if.range_high <= b.range_high;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_beat(b);
    burst_left--;
    @(negedge clk_i);
  endtask

  // stop sending, let every owed result arrive and the sequencer settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_maxima.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_count(int unsigned c);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= CountWidth'(c);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    tracker.set_count(c);
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    rmq_res_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.max_value = out_if.max_value;
      got.max_index = out_if.max_index;
      got.found     = out_if.found;
      tracker.check_result(got);
    end
  end

  // receiver: always ready, random stalls, or a fixed stall/run pattern,
  // switching mode after each span of random length
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned stall_len;
    out_if.ready = 1'b0;
    forever begin
      mode      = $urandom_range(0, 2);
      span      = $urandom_range(40, 200);
      period    = $urandom_range(4, 16);
      stall_len = $urandom_range(1, period - 1);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 99) < 60);
          default: out_if.ready <= ((k % period) >= stall_len);
        endcase
      end
    end
  end

  // main sequence
  initial begin
    int unsigned phase_counts [8];
    in_if.valid      = 1'b0;
    in_if.action     = ActLoad;
    in_if.position   = '0;
    in_if.value      = '0;
    in_if.range_low  = '0;
    in_if.range_high = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // node memory comes up unknown: every position gets a value before any query
    for (int unsigned p = 0; p < SizeDefault; p++) send(load_beat(p, rand_value()));

    // directed: extremes at both ends, a tie on the global max
    send(load_beat(0, 32'sh8000_0000));
    send(load_beat(SizeDefault - 1, 32'sh7fff_ffff));
    send(load_beat(64, 32'sh7fff_ffff));
    send(query_beat(0, SizeDefault));            // tie resolves to the right end
    send(query_beat(0, SizeDefault - 1));        // only the middle copy left
    send(query_beat(0, 1));
    send(query_beat(SizeDefault - 1, SizeDefault));
    send(query_beat(SizeDefault, SizeDefault));  // empty at the top
    send(query_beat(0, 0));                      // empty at the bottom
    send(query_beat(90, 10));                    // reversed, empty
    send(query_beat(SizeDefault, 0));
    // run of equal minimum values, rightmost must win
    for (int unsigned p = 100; p < 104; p++) send(load_beat(p, 32'sh8000_0000));
    send(query_beat(100, 104));

    // count of one clips everything to the first element
    wait_idle();
    write_count(1);
    send(query_beat(0, SizeDefault));
    send(query_beat(1, SizeDefault));            // clipped to empty
    send(load_beat(SizeDefault - 1, -1));        // stored beyond the count
    send(query_beat(0, 1));
    wait_idle();
    write_count(SizeDefault);
    send(query_beat(SizeDefault - 1, SizeDefault)); // the load above now shows

    // random phases across several counts, the extremes among them
    phase_counts = '{128, 1, 2, 127, 64, 0, 0, 128};
    phase_counts[5] = $urandom_range(3, 63);
    phase_counts[6] = $urandom_range(65, 126);
    for (int unsigned ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_count(phase_counts[ph]);
      no_gaps = (ph % 3 == 1);
      repeat (150) send(rand_item(phase_counts[ph]));
    end

    wait_idle();

    $display("ran %0d loads and %0d queries (%0d empty) over %0d count settings",
             tracker.n_loads, tracker.n_queries, tracker.n_empty, n_cfg);
    $display("checked %0d results, %0d mismatches, %0d left unanswered",
             tracker.n_checked, tracker.mismatches, tracker.pending_maxima.size());
    if (tracker.mismatches == 0 && tracker.pending_maxima.size() == 0) begin
      $display("** range_max_query_tree: PASSED **");
    end else begin
      $display("** range_max_query_tree: FAILED **");
    end
    $finish;
  end

endmodule
